[hdl/rpn_stack_calculator_macros.svh]
// Assertion macros for the RPN stack calculator.
// Included by the top level; no other dependencies.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RPNC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("rpnc assertion failed");
`define RPNC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("rpnc assertion failed");
`else
`define RPNC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RPNC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

[hdl/rpnc_pkg.sv]
// Shared types and constants for the RPN stack calculator.
// No dependencies; used by controller, datapath, divider and top level.
`default_nettype none

package rpnc_pkg;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_OPER  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_ILLEGAL = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    cap;     // latch the input item
    logic    push;    // write pushed value, count up
    logic    clr;     // empty the stack
    logic    rd;      // read the two top entries
    logic    mul_go;  // register the product
    logic    div_go;  // start the divider
    logic    wb;      // write ALU result over the operands, count down
    logic    out_ld;  // load the output register
    status_t st;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic [2:0] op;
    logic       full;
    logic       lt2;
    logic       rhs_zero;
    logic       div_done;
  } sts_t;

endpackage

`default_nettype wire

[hdl/rpnc_div.sv]
// Iterative Q16.16 divider, one quotient bit per cycle, truncating and saturating.
// Depends on rpnc_pkg.
`default_nettype none

module rpnc_div
  import rpnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] lhs,
  input  logic signed [31:0] rhs,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int STEPS = 32;
  localparam int SW    = $clog2(STEPS);

  logic          busy_r;
  logic [SW-1:0] cnt_r;
  logic          done_r;
  logic [31:0]   rem_r;
  logic [31:0]   q_r;
  logic [31:0]   dvs_r;
  logic          neg_r;
  logic          ovf_r;

  logic [31:0] mag_l;
  logic [31:0] mag_r;
  logic        ovf_chk;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  assign mag_l = lhs[31] ? (~lhs + 32'd1) : lhs;
  assign mag_r = rhs[31] ? (~rhs + 32'd1) : rhs;
  // quotient would need more than 32 bits: saturate without iterating the top bits
  assign ovf_chk = {16'd0, mag_l} >= {mag_r, 16'd0};

  assign shifted = {rem_r, q_r[31]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SW'(1);
        if (cnt_r == SW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // numerator is mag_l << 16; its top 16 bits seed the remainder
      rem_r <= {16'd0, mag_l[31:16]};
      q_r   <= {mag_l[15:0], 16'd0};
      dvs_r <= mag_r;
      neg_r <= lhs[31] ^ rhs[31];
      ovf_r <= ovf_chk;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      q_r   <= {q_r[30:0], ge};
    end
  end

  always_comb begin
    if (ovf_r) begin
      quo = neg_r ? Q_MIN : Q_MAX;
    end else if (!neg_r) begin
      quo = q_r[31] ? Q_MAX : q_r;
    end else if (q_r[31] && (|q_r[30:0])) begin
      quo = Q_MIN;
    end else begin
      quo = ~q_r + 32'd1;
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

[hdl/rpnc_dp.sv]
// Datapath: operand stack memory, stack count, ALU with saturation, output register.
// Depends on rpnc_pkg and rpnc_div.
`default_nettype none

module rpnc_dp
  import rpnc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_push_value,
  input  logic [2:0]         in_op_code,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status,
  output logic [4:0]         out_stack_depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic signed [31:0] stack_mem [STACK_DEPTH];

  logic [CW-1:0]      count_r;
  logic [1:0]         req_r;
  logic [2:0]         op_r;
  logic signed [31:0] pv_r;
  logic signed [31:0] rhs_r;
  logic signed [31:0] lhs_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic signed [31:0] out_res_r;
  status_t            out_st_r;
  logic [4:0]         out_depth_r;

  logic [CW-1:0]      cm1;
  logic [CW-1:0]      cm2;
  logic [CW+4:0]      cnt_ext;
  logic [32:0]        sum;
  logic [32:0]        dif;
  logic signed [63:0] rnd;
  logic signed [31:0] mul_sat;
  logic signed [31:0] alu_res;
  logic               div_done;
  logic signed [31:0] div_quo;

  function automatic logic signed [31:0] sat33(input logic [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q_MIN : Q_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign cm1     = count_r - CW'(1);
  assign cm2     = count_r - CW'(2);
  assign cnt_ext = {5'd0, count_r};

  assign sum = {lhs_r[31], lhs_r} + {rhs_r[31], rhs_r};
  assign dif = {lhs_r[31], lhs_r} - {rhs_r[31], rhs_r};

  // round to nearest, ties up, then arithmetic shift by 16
  assign rnd = prod_r + 64'sd32768;
  always_comb begin
    if ((&rnd[63:47]) || !(|rnd[63:47])) begin
      mul_sat = rnd[47:16];
    end else begin
      mul_sat = rnd[63] ? Q_MIN : Q_MAX;
    end
  end

  rpnc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .lhs   (lhs_r),
    .rhs   (rhs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = sat33(sum);
      OP_SUB:  alu_res = sat33(dif);
      OP_MUL:  alu_res = mul_sat;
      OP_DIV:  alu_res = div_quo;
      default: alu_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count_r[AW-1:0]] <= pv_r;
    end else if (cmd.wb) begin
      stack_mem[cm2[AW-1:0]] <= alu_res;
    end
    if (cmd.rd) begin
      rhs_r <= stack_mem[cm1[AW-1:0]];
      lhs_r <= stack_mem[cm2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.wb) begin
      count_r <= cm1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      op_r  <= in_op_code;
      pv_r  <= in_push_value;
      res_r <= '0;
    end else if (cmd.push) begin
      res_r <= pv_r;
    end else if (cmd.wb) begin
      res_r <= alu_res;
    end
    if (cmd.mul_go) begin
      prod_r <= lhs_r * rhs_r;
    end
    if (cmd.out_ld) begin
      out_res_r   <= res_r;
      out_st_r    <= cmd.st;
      out_depth_r <= cnt_ext[4:0];
    end
  end

  assign sts.req      = req_r;
  assign sts.op       = op_r;
  assign sts.full     = count_r >= DEPTH_C;
  assign sts.lt2      = count_r < CW'(2);
  assign sts.rhs_zero = rhs_r == '0;
  assign sts.div_done = div_done;

  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;
  assign out_stack_depth  = out_depth_r;

endmodule

`default_nettype wire

[hdl/rpnc_ctrl.sv]
// Controller state machine: sequences each item through the datapath.
// Depends on rpnc_pkg.
`default_nettype none

module rpnc_ctrl
  import rpnc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_EXEC = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.st        = st_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        case (sts.req)
          REQ_PUSH: begin
            if (sts.full) begin
              st_nxt = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end
          REQ_OPER: begin
            // depth is checked before the operator code
            if (sts.lt2) begin
              st_nxt = ST_UNDER;
            end else if (sts.op > OP_DIV) begin
              st_nxt = ST_ILLEGAL;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          REQ_CLEAR: cmd.clr = 1'b1;
          default: ;
        endcase
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (sts.op)
          OP_ADD, OP_SUB: cmd.wb = 1'b1;
          OP_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt  = S_MUL;
          end
          OP_DIV: begin
            if (sts.rhs_zero) begin
              st_nxt = ST_DIVZ;
            end else begin
              cmd.div_go = 1'b1;
              state_nxt  = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        cmd.wb    = 1'b1;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wb    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/rpn_stack_calculator.sv]
// RPN stack calculator, Q16.16 operands on a stack of STACK_DEPTH entries.
// Input channel (in_*): req_type push / operate / clear, push_value, op_code.
// Output channel (out_*): one result per input item: result_value, status,
// stack_depth (entries after the item, modulo 32), each a valid/ready transfer.
// One item is in work at a time; in_ready is high only while the block is idle.
// Path from input transfer to out_valid: decode then finish for push, clear,
// ignored requests and faults found at decode (overflow, underflow, illegal
// operator); add/subtract and divide by zero also pass an execute state,
// multiply adds a product state, and divide waits on the bit-serial divider (32
// iterations, one quotient bit per cycle). in_ready rises in the same cycle
// as out_valid, so the next item can enter while that result still waits.
// If the receiver stalls, the finished result holds in the output register;
// the next item is processed and then waits for that register to drain.
// Reset (rst_n, synchronous, active low) empties the stack and drops out_valid;
// stack contents are not cleared, only the count.
// Depends on rpnc_pkg, rpnc_ctrl, rpnc_dp and the assertion macro header.
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator
  import rpnc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_push_value,
  input  logic [2:0]         in_op_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status,
  output logic [4:0]         out_stack_depth
);

  cmd_t cmd;
  sts_t sts;

  rpnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rpnc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_push_value    (in_push_value),
    .in_op_code       (in_op_code),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_stack_depth  (out_stack_depth)
  );

  `RPNC_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)
  `RPNC_ASSERT_IMP(a_push_not_full, clk, rst_n, cmd.push, !sts.full)
  `RPNC_ASSERT_IMP(a_one_stack_update, clk, rst_n, 1'b1, $onehot0({cmd.push, cmd.wb, cmd.clr}))
  `RPNC_ASSERT_IMP(a_fault_zero_result, clk, rst_n, out_valid && (out_status != ST_OK), out_result_value == '0)

endmodule

`default_nettype wire
